/* hdl/c2d_pkg.sv */
// shared types, constants and helpers for the 2d convolution block
`default_nettype none

package c2d_pkg;

    localparam int MAX_IMAGE_DIM_DEF  = 32;
    localparam int MAX_KERNEL_DIM_DEF = 5;
    localparam int SAMPLE_BITS_DEF    = 16;

    localparam int CW        = 10;
    localparam int SUM_W     = 37;
    localparam int IN_IDX_W  = 6;
    localparam int ACT_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int DIM_REG_W = 6;
    localparam int SML_REG_W = 3;
    localparam int DRAIN_CYCLES = 2;
    localparam int DRAIN_W      = 2;

    localparam logic [ACT_W-1:0] ACT_WR_KERNEL = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WR_IMAGE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_ROWS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_COLS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_ROWS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_COLS    = 3'd7;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic [CW-1:0] ir;
        logic [CW-1:0] ic;
        logic [CW-1:0] kr;
        logic [CW-1:0] kc;
        logic [CW-1:0] sr;
        logic [CW-1:0] sc;
        logic [CW-1:0] pr;
        logic [CW-1:0] pc;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic tap;
    } mac_ctl_t;

    typedef struct packed {
        logic valid;
        logic err;
    } seq_done_t;

    function automatic logic [CW-1:0] clamp_val(logic [CW-1:0] v, logic [CW-1:0] lo,
                                                logic [CW-1:0] hi);
        logic [CW-1:0] r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/c2d_ram.sv */
// single write port, single registered read port memory
`default_nettype none

module c2d_ram #(
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [0:(1<<ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

/* hdl/c2d_mac.sv */
// shared multiply-accumulate unit with product and sum registers
`default_nettype none

module c2d_mac
    import c2d_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mac_ctl_t                      ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] img_data,
    input  wire logic signed [SAMPLE_BITS-1:0] ker_data,
    output logic             [SUM_W-1:0]       acc
);

    localparam int PW = 2 * SAMPLE_BITS;

    logic                 tap1_reg;
    logic                 tap2_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic [SUM_W-1:0]     acc_reg;
    logic [SUM_W-1:0]     acc_next;

    // tap flag delayed to line up with the registered memory data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap1_reg <= 1'b0;
            tap2_reg <= 1'b0;
        end
        else
        begin
            tap1_reg <= ctl.tap;
            tap2_reg <= tap1_reg;
        end
    end

    always_comb
    begin
        prod_next = '0;
        if (tap1_reg)
        begin
            prod_next = img_data * ker_data;
        end
        acc_next  = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (tap2_reg)
        begin
            acc_next = acc_reg + SUM_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

/* hdl/c2d_seq.sv */
// sequencer: grid check and kernel window walk, one tap per cycle
`default_nettype none

module c2d_seq
    import c2d_pkg::*;
#(
    parameter int MAX_IMAGE_DIM  = MAX_IMAGE_DIM_DEF,
    parameter int MAX_KERNEL_DIM = MAX_KERNEL_DIM_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_t                cfg,
    input  wire logic                start,
    input  wire logic [IN_IDX_W-1:0] row_index,
    input  wire logic [IN_IDX_W-1:0] col_index,
    input  wire logic                out_free,
    output logic                     busy,
    output logic [$clog2(MAX_IMAGE_DIM)-1:0] img_row,
    output logic [$clog2(MAX_IMAGE_DIM)-1:0] img_col,
    output logic [((MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1)-1:0] ker_row,
    output logic [((MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1)-1:0] ker_col,
    output mac_ctl_t                 mac_ctl,
    output seq_done_t                done
);

    localparam int IDX_W  = $clog2(MAX_IMAGE_DIM);
    localparam int KIDX_W = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1;

    seq_state_t           state_reg, state_next;
    logic [IN_IDX_W-1:0]  r_reg, r_next;
    logic [IN_IDX_W-1:0]  c_reg, c_next;
    logic [CW-1:0]        base_r_reg, base_r_next;
    logic [CW-1:0]        base_c_reg, base_c_next;
    logic [KIDX_W-1:0]    x_reg, x_next;
    logic [KIDX_W-1:0]    y_reg, y_next;
    logic                 err_reg, err_next;
    logic [DRAIN_W-1:0]   drain_reg, drain_next;

    logic [CW-1:0] mul_r;
    logic [CW-1:0] mul_c;
    logic [CW-1:0] py;
    logic [CW-1:0] px;
    logic [CW-1:0] py_img;
    logic [CW-1:0] px_img;
    logic          in_image;
    logic          last_col;
    logic          last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        c_reg      <= c_next;
        base_r_reg <= base_r_next;
        base_c_reg <= base_c_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        err_reg    <= err_next;
    end

    always_comb
    begin
        mul_r    = CW'(r_reg) * cfg.sr;
        mul_c    = CW'(c_reg) * cfg.sc;
        py       = base_r_reg + CW'(x_reg);
        px       = base_c_reg + CW'(y_reg);
        py_img   = py - cfg.pr;
        px_img   = px - cfg.pc;
        in_image = (py >= cfg.pr) && (py_img < cfg.ir) && (px >= cfg.pc) && (px_img < cfg.ic);
        last_col = (CW'(y_reg) == cfg.kc - CW'(1));
        last_row = (CW'(x_reg) == cfg.kr - CW'(1));

        state_next  = state_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        base_r_next = base_r_reg;
        base_c_next = base_c_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        err_next    = err_reg;
        drain_next  = drain_reg;

        busy          = (state_reg != ST_IDLE);
        img_row       = IDX_W'(py_img);
        img_col       = IDX_W'(px_img);
        ker_row       = x_reg;
        ker_col       = y_reg;
        mac_ctl.clear = 1'b0;
        mac_ctl.tap   = 1'b0;
        done.valid    = 1'b0;
        done.err      = err_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    r_next     = row_index;
                    c_next     = col_index;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                mac_ctl.clear = 1'b1;
                base_r_next   = mul_r;
                base_c_next   = mul_c;
                x_next        = '0;
                y_next        = '0;
                // window must fit inside the padded image
                err_next = (mul_r + cfg.kr > cfg.ir + (cfg.pr << 1))
                        || (mul_c + cfg.kc > cfg.ic + (cfg.pc << 1));
                state_next = err_next ? ST_DONE : ST_RUN;
            end
            ST_RUN:
            begin
                mac_ctl.tap = in_image;
                if (last_col)
                begin
                    y_next = '0;
                    x_next = x_reg + KIDX_W'(1);
                    if (last_row)
                    begin
                        drain_next = '0;
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    y_next = y_reg + KIDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + DRAIN_W'(1);
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done.valid = 1'b1;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/conv2d_stride_pad.sv */
// conv2d_stride_pad: one-sample-at-a-time windowed sum of products over a padded image
// weight and sample writes give no result word
// an output request passes setup, the kernel tap walk, drain and done before its result word;
//   the single multiply-accumulate unit takes one kernel tap per cycle
// out-of-grid request: setup goes straight to done; no new request is taken while the sequencer is busy
// reset restores the register defaults; image and kernel memories hold no reset value
`default_nettype none

module conv2d_stride_pad
    import c2d_pkg::*;
#(
    parameter int MAX_IMAGE_DIM  = MAX_IMAGE_DIM_DEF,
    parameter int MAX_KERNEL_DIM = MAX_KERNEL_DIM_DEF,
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ACT_W-1:0]              action,
    input  wire logic [IN_IDX_W-1:0]           row_index,
    input  wire logic [IN_IDX_W-1:0]           col_index,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SUM_W-1:0]            conv_sum,
    output logic                               status,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [DIM_REG_W-1:0]          cfg_data
);

    localparam int IDX_W  = $clog2(MAX_IMAGE_DIM);
    localparam int KIDX_W = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1;

    logic [DIM_REG_W-1:0] image_rows_reg;
    logic [DIM_REG_W-1:0] image_cols_reg;
    logic [SML_REG_W-1:0] kernel_rows_reg;
    logic [SML_REG_W-1:0] kernel_cols_reg;
    logic [SML_REG_W-1:0] stride_rows_reg;
    logic [SML_REG_W-1:0] stride_cols_reg;
    logic [SML_REG_W-1:0] pad_rows_reg;
    logic [SML_REG_W-1:0] pad_cols_reg;

    cfg_t cfg;

    logic                    in_accept;
    logic                    start;
    logic                    img_we;
    logic                    ker_we;
    logic                    busy;
    logic                    out_free;
    logic [IDX_W-1:0]        img_row;
    logic [IDX_W-1:0]        img_col;
    logic [KIDX_W-1:0]       ker_row;
    logic [KIDX_W-1:0]       ker_col;
    mac_ctl_t                mac_ctl;
    seq_done_t               done;
    logic [SAMPLE_BITS-1:0]  img_rdata;
    logic [SAMPLE_BITS-1:0]  ker_rdata;
    logic [SUM_W-1:0]        acc;

    logic                    out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]        conv_sum_reg, conv_sum_next;
    logic                    status_reg, status_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg  <= DIM_REG_W'(32);
            image_cols_reg  <= DIM_REG_W'(32);
            kernel_rows_reg <= SML_REG_W'(3);
            kernel_cols_reg <= SML_REG_W'(3);
            stride_rows_reg <= SML_REG_W'(1);
            stride_cols_reg <= SML_REG_W'(1);
            pad_rows_reg    <= '0;
            pad_cols_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_ROWS:  image_rows_reg  <= cfg_data;
                CFG_IMAGE_COLS:  image_cols_reg  <= cfg_data;
                CFG_KERNEL_ROWS: kernel_rows_reg <= cfg_data[SML_REG_W-1:0];
                CFG_KERNEL_COLS: kernel_cols_reg <= cfg_data[SML_REG_W-1:0];
                CFG_STRIDE_ROWS: stride_rows_reg <= cfg_data[SML_REG_W-1:0];
                CFG_STRIDE_COLS: stride_cols_reg <= cfg_data[SML_REG_W-1:0];
                CFG_PAD_ROWS:    pad_rows_reg    <= cfg_data[SML_REG_W-1:0];
                CFG_PAD_COLS:    pad_cols_reg    <= cfg_data[SML_REG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.ir = clamp_val(CW'(image_rows_reg), CW'(1), CW'(MAX_IMAGE_DIM));
        cfg.ic = clamp_val(CW'(image_cols_reg), CW'(1), CW'(MAX_IMAGE_DIM));
        cfg.kr = clamp_val(CW'(kernel_rows_reg), CW'(1), CW'(MAX_KERNEL_DIM));
        cfg.kc = clamp_val(CW'(kernel_cols_reg), CW'(1), CW'(MAX_KERNEL_DIM));
        cfg.sr = clamp_val(CW'(stride_rows_reg), CW'(1), CW'(4));
        cfg.sc = clamp_val(CW'(stride_cols_reg), CW'(1), CW'(4));
        cfg.pr = clamp_val(CW'(pad_rows_reg), CW'(0), CW'(4));
        cfg.pc = clamp_val(CW'(pad_cols_reg), CW'(0), CW'(4));
    end

    assign in_stall  = busy;
    assign in_accept = in_valid && !in_stall;
    assign start     = in_accept && (action == ACT_COMPUTE);
    assign img_we    = in_accept && (action == ACT_WR_IMAGE)
                    && (CW'(row_index) < cfg.ir) && (CW'(col_index) < cfg.ic);
    assign ker_we    = in_accept && (action == ACT_WR_KERNEL)
                    && (CW'(row_index) < cfg.kr) && (CW'(col_index) < cfg.kc);

    c2d_ram #(
        .WIDTH  (SAMPLE_BITS),
        .ADDR_W (2 * IDX_W)
    ) u_image_ram (
        .clk   (clk),
        .we    (img_we),
        .waddr ({IDX_W'(row_index), IDX_W'(col_index)}),
        .wdata (sample_value),
        .raddr ({img_row, img_col}),
        .rdata (img_rdata)
    );

    c2d_ram #(
        .WIDTH  (SAMPLE_BITS),
        .ADDR_W (2 * KIDX_W)
    ) u_kernel_ram (
        .clk   (clk),
        .we    (ker_we),
        .waddr ({KIDX_W'(row_index), KIDX_W'(col_index)}),
        .wdata (sample_value),
        .raddr ({ker_row, ker_col}),
        .rdata (ker_rdata)
    );

    c2d_seq #(
        .MAX_IMAGE_DIM  (MAX_IMAGE_DIM),
        .MAX_KERNEL_DIM (MAX_KERNEL_DIM)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .start     (start),
        .row_index (row_index),
        .col_index (col_index),
        .out_free  (out_free),
        .busy      (busy),
        .img_row   (img_row),
        .img_col   (img_col),
        .ker_row   (ker_row),
        .ker_col   (ker_col),
        .mac_ctl   (mac_ctl),
        .done      (done)
    );

    c2d_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mac_ctl),
        .img_data (img_rdata),
        .ker_data (ker_rdata),
        .acc      (acc)
    );

    // output word register
    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg && out_stall;
        conv_sum_next  = conv_sum_reg;
        status_next    = status_reg;
        if (done.valid && out_free)
        begin
            out_valid_next = 1'b1;
            conv_sum_next  = done.err ? '0 : acc;
            status_next    = done.err ? STATUS_RANGE : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        conv_sum_reg <= conv_sum_next;
        status_reg   <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign conv_sum  = conv_sum_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

/* dv/conv2d_stride_pad_tb.sv */
// self-checking testbench for the strided, zero-padded 2d convolution block
`default_nettype none

module conv2d_stride_pad_tb
    import c2d_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IMG_MAX    = MAX_IMAGE_DIM_DEF;
    localparam int KER_MAX    = MAX_KERNEL_DIM_DEF;
    localparam int STRIDE_MAX = 4;
    localparam int PAD_MAX    = 4;
    localparam int SBITS      = SAMPLE_BITS_DEF;
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

    typedef struct {
        logic signed [SUM_W-1:0] total;
        logic                    stat;
    } conv_result_t;

    class conv_scoreboard;
        bit signed [SBITS-1:0]  image_mem [IMG_MAX][IMG_MAX];
        bit signed [SBITS-1:0]  kernel_mem [KER_MAX][KER_MAX];
        bit                     image_set [IMG_MAX][IMG_MAX];
        bit                     kernel_set [KER_MAX][KER_MAX];
        logic [DIM_REG_W-1:0]   reg_val [8];
        int                     ir, ic, kr, kc, sr, sc, pr, pc;
        int                     rows_out, cols_out;
        int                     ready_pts[$];
        conv_result_t           due_q[$];
        int                     fail_count, n_ok, n_range;

        function new();
            reg_val[CFG_IMAGE_ROWS]  = 6'd32;
            reg_val[CFG_IMAGE_COLS]  = 6'd32;
            reg_val[CFG_KERNEL_ROWS] = 6'd3;
            reg_val[CFG_KERNEL_COLS] = 6'd3;
            reg_val[CFG_STRIDE_ROWS] = 6'd1;
            reg_val[CFG_STRIDE_COLS] = 6'd1;
            reg_val[CFG_PAD_ROWS]    = 6'd0;
            reg_val[CFG_PAD_COLS]    = 6'd0;
            update_geometry();
        endfunction

        function int limit(int v, int lo, int hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void update_geometry();
            ir = limit(reg_val[CFG_IMAGE_ROWS], 1, IMG_MAX);
            ic = limit(reg_val[CFG_IMAGE_COLS], 1, IMG_MAX);
            kr = limit(reg_val[CFG_KERNEL_ROWS], 1, KER_MAX);
            kc = limit(reg_val[CFG_KERNEL_COLS], 1, KER_MAX);
            sr = limit(reg_val[CFG_STRIDE_ROWS], 1, STRIDE_MAX);
            sc = limit(reg_val[CFG_STRIDE_COLS], 1, STRIDE_MAX);
            pr = limit(reg_val[CFG_PAD_ROWS], 0, PAD_MAX);
            pc = limit(reg_val[CFG_PAD_COLS], 0, PAD_MAX);
            rows_out = (ir + 2 * pr >= kr) ? (ir + 2 * pr - kr) / sr + 1 : 0;
            cols_out = (ic + 2 * pc >= kc) ? (ic + 2 * pc - kc) / sc + 1 : 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_REG_W-1:0] d);
            if (idx == CFG_IMAGE_ROWS || idx == CFG_IMAGE_COLS)
                reg_val[idx] = d;
            else
                reg_val[idx] = d & 6'h07;
            update_geometry();
        endfunction

        // grid points whose in-image taps all hit written samples and weights
        function void refresh_ready();
            bit ok;
            int py, px;
            ready_pts.delete();
            for (int r = 0; r < rows_out; r++)
            begin
                for (int c = 0; c < cols_out; c++)
                begin
                    ok = 1'b1;
                    for (int x = 0; x < kr; x++)
                    begin
                        py = r * sr + x - pr;
                        for (int y = 0; y < kc; y++)
                        begin
                            px = c * sc + y - pc;
                            if (py >= 0 && py < ir && px >= 0 && px < ic)
                            begin
                                if (!image_set[py][px] || !kernel_set[x][y])
                                    ok = 1'b0;
                            end
                        end
                    end
                    if (ok)
                        ready_pts = {ready_pts, r * 64 + c};
                end
            end
        endfunction

        function void note_input(logic [ACT_W-1:0] act, logic [IN_IDX_W-1:0] r,
                                 logic [IN_IDX_W-1:0] c, logic signed [SBITS-1:0] v);
            conv_result_t res;
            longint       acc;
            int           py, px;
            case (act)
                ACT_WR_KERNEL:
                begin
                    if (r < kr && c < kc)
                    begin
                        kernel_mem[r][c] = v;
                        kernel_set[r][c] = 1'b1;
                    end
                end
                ACT_WR_IMAGE:
                begin
                    if (r < ir && c < ic)
                    begin
                        image_mem[r][c] = v;
                        image_set[r][c] = 1'b1;
                    end
                end
                ACT_COMPUTE:
                begin
                    if (r >= rows_out || c >= cols_out)
                    begin
                        res.total = '0;
                        res.stat  = STATUS_RANGE;
                        n_range++;
                    end
                    else
                    begin
                        acc = 0;
                        for (int x = 0; x < kr; x++)
                        begin
                            py = int'(r) * sr + x - pr;
                            for (int y = 0; y < kc; y++)
                            begin
                                px = int'(c) * sc + y - pc;
                                if (py >= 0 && py < ir && px >= 0 && px < ic)
                                    acc += longint'(image_mem[py][px])
                                           * longint'(kernel_mem[x][y]);
                            end
                        end
                        res.total = SUM_W'(acc);
                        res.stat  = STATUS_OK;
                        n_ok++;
                    end
                    due_q = {due_q, res};
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(logic signed [SUM_W-1:0] got_total, logic got_stat);
            conv_result_t want;
            if (due_q.size() == 0)
            begin
                $error("result word with nothing expected: conv_sum %0d status %0d",
                       got_total, got_stat);
                fail_count++;
                return;
            end
            want = due_q.pop_front();
            if (got_total !== want.total)
            begin
                $error("conv_sum mismatch: expected %0d, actual %0d", want.total, got_total);
                fail_count++;
            end
            if (got_stat !== want.stat)
            begin
                $error("status mismatch: expected %0d, actual %0d", want.stat, got_stat);
                fail_count++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [ACT_W-1:0]              action;
    logic [IN_IDX_W-1:0]           row_index;
    logic [IN_IDX_W-1:0]           col_index;
    logic signed [SBITS-1:0]       sample_value;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [SUM_W-1:0]       conv_sum;
    logic                          status;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [DIM_REG_W-1:0]          cfg_data;

    conv_scoreboard sb;
    bit             no_gaps;
    bit             hold_req;
    int             n_words;
    int             n_settings;

    conv2d_stride_pad dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .row_index    (row_index),
        .col_index    (col_index),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .conv_sum     (conv_sum),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("** conv2d_stride_pad: FAILED **");
        $finish;
    end

    function automatic logic [SBITS-1:0] pick_sample();
        int p;
        p = $urandom_range(9);
        if (p == 0)
            return 16'h8000;
        if (p == 1)
            return 16'h7fff;
        return SBITS'($urandom);
    endfunction

    task automatic push_word(input logic [ACT_W-1:0] act, input int r, input int c,
                             input logic [SBITS-1:0] v);
        while (!no_gaps && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        row_index    <= IN_IDX_W'(r);
        col_index    <= IN_IDX_W'(c);
        sample_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(act, IN_IDX_W'(r), IN_IDX_W'(c), v);
        n_words++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DIM_REG_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, d);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.due_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // k < 0: small directed setup; 0..3: extremes and saturation; else random
    task automatic setup_phase(input int k);
        logic [DIM_REG_W-1:0] setting [8];
        for (int i = 0; i < 8; i++)
            setting[i] = 6'($urandom_range(7));
        if ($urandom_range(4) == 0)
        begin
            setting[CFG_IMAGE_ROWS] = 6'($urandom_range(63));
            setting[CFG_IMAGE_COLS] = 6'($urandom_range(63));
        end
        else
        begin
            setting[CFG_IMAGE_ROWS] = 6'($urandom_range(8, 1));
            setting[CFG_IMAGE_COLS] = 6'($urandom_range(8, 1));
        end
        if (k < 0)
        begin
            setting = '{6'd3, 6'd3, 6'd3, 6'd3, 6'd1, 6'd1, 6'd0, 6'd0};
        end
        else if (k == 0)
        begin
            setting = '{6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd0, 6'd0};
        end
        else if (k == 1)
        begin
            // kernel larger than the padded image
            setting = '{6'd1, 6'd2, 6'd5, 6'd5, 6'd4, 6'd4, 6'd0, 6'd0};
        end
        else if (k == 2)
        begin
            setting = '{6'd63, 6'd32, 6'd5, 6'd5, 6'd4, 6'd4, 6'd4, 6'd4};
        end
        else if (k == 3)
        begin
            // zero and oversized register values saturate
            setting = '{6'd0, 6'd0, 6'd7, 6'd7, 6'd0, 6'd0, 6'd7, 6'd7};
        end
        for (int i = 0; i < 8; i++)
            cfg_write(CFG_IDX_W'(i), setting[i]);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic load_data();
        int r0, c0, h, w;
        for (int x = 0; x < sb.kr; x++)
        begin
            for (int y = 0; y < sb.kc; y++)
            begin
                if (!sb.kernel_set[x][y] || $urandom_range(1))
                    push_word(ACT_WR_KERNEL, x, y, pick_sample());
            end
        end
        h  = (sb.ir * sb.ic <= 36 || sb.ir < 6) ? sb.ir : 6;
        w  = (sb.ir * sb.ic <= 36 || sb.ic < 6) ? sb.ic : 6;
        r0 = $urandom_range(sb.ir - h);
        c0 = $urandom_range(sb.ic - w);
        for (int r = r0; r < r0 + h; r++)
        begin
            for (int c = c0; c < c0 + w; c++)
                push_word(ACT_WR_IMAGE, r, c, pick_sample());
        end
        sb.refresh_ready();
    endtask

    task automatic run_mix(input int n, input bit with_hold);
        int pick, pt, r, c;
        for (int i = 0; i < n; i++)
        begin
            if (with_hold && i == 10)
                hold_req = 1'b1;
            pick = $urandom_range(99);
            if (pick < 55 && sb.ready_pts.size() != 0)
            begin
                pt = sb.ready_pts[$urandom_range(sb.ready_pts.size() - 1)];
                push_word(ACT_COMPUTE, pt / 64, pt % 64, SBITS'($urandom));
            end
            else if (pick < 65)
            begin
                if ($urandom_range(1))
                begin
                    r = $urandom_range(63, sb.rows_out);
                    c = $urandom_range(63);
                end
                else
                begin
                    r = $urandom_range(63);
                    c = $urandom_range(63, sb.cols_out);
                end
                push_word(ACT_COMPUTE, r, c, SBITS'($urandom));
            end
            else if (pick < 80)
            begin
                if ($urandom_range(3) != 0)
                    push_word(ACT_WR_IMAGE, $urandom_range(sb.ir - 1),
                              $urandom_range(sb.ic - 1), pick_sample());
                else
                    push_word(ACT_WR_IMAGE, $urandom_range(63), $urandom_range(63),
                              pick_sample());
            end
            else if (pick < 92)
            begin
                if ($urandom_range(3) != 0)
                    push_word(ACT_WR_KERNEL, $urandom_range(sb.kr - 1),
                              $urandom_range(sb.kc - 1), pick_sample());
                else
                    push_word(ACT_WR_KERNEL, $urandom_range(63), $urandom_range(63),
                              pick_sample());
            end
            else
            begin
                push_word(ACT_NONE, $urandom_range(63), $urandom_range(63), pick_sample());
            end
        end
    endtask

    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result(conv_sum, status);
            if (hold_req && !hold_done)
            begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !no_gaps && ($urandom_range(99) < 29);
            end
        end
    end

    initial
    begin
        sb           = new();
        no_gaps      = 1'b0;
        hold_req     = 1'b0;
        n_words      = 0;
        n_settings   = 0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= ACT_WR_KERNEL;
        row_index    <= '0;
        col_index    <= '0;
        sample_value <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_IMAGE_ROWS;
        cfg_data     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme values, ignored writes, unused action, in-grid and off-grid requests
        setup_phase(-1);
        for (int x = 0; x < 3; x++)
        begin
            for (int y = 0; y < 3; y++)
                push_word(ACT_WR_KERNEL, x, y, 16'h8000);
        end
        for (int x = 0; x < 3; x++)
        begin
            for (int y = 0; y < 3; y++)
                push_word(ACT_WR_IMAGE, x, y, (x == 0 && y == 0) ? 16'h8000 : 16'h7fff);
        end
        push_word(ACT_WR_KERNEL, 63, 63, 16'h7fff);
        push_word(ACT_WR_IMAGE, 63, 0, 16'h7fff);
        push_word(ACT_NONE, 63, 63, 16'h5555);
        push_word(ACT_COMPUTE, 0, 0, 16'h0000);
        push_word(ACT_COMPUTE, 1, 0, 16'hffff);
        push_word(ACT_COMPUTE, 0, 63, 16'h0000);
        push_word(ACT_COMPUTE, 63, 63, 16'hffff);

        for (int k = 0; k < 16; k++)
        begin
            wait_idle();
            no_gaps = (k == 6 || k == 7);
            setup_phase(k);
            load_data();
            run_mix(55, k == 9);
        end
        wait_idle();

        $display("covered %0d input words over %0d register settings",
                 n_words, n_settings);
        $display("checked %0d window sums and %0d out-of-grid answers",
                 sb.n_ok, sb.n_range);
        if (sb.fail_count == 0 && sb.due_q.size() == 0)
            $display("** conv2d_stride_pad: PASSED **");
        else
            $display("** conv2d_stride_pad: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
